FILE: rtl/lkp_pkg.sv
// Package for the LED-and-key panel serial master.
// Command codes, frame constants, glyph table, controller state and control struct.
// No dependencies.
package lkp_pkg;

	// command codes
	localparam logic [1:0] CMD_DIGIT = 2'd0;
	localparam logic [1:0] CMD_LED   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// chip command bytes
	localparam logic [7:0] OP_WRITE_FIXED = 8'h40;
	localparam logic [7:0] OP_WRITE_LED   = 8'h44;
	localparam logic [7:0] OP_READ_KEYS   = 8'h42;
	localparam logic [7:0] ADDR_DIGIT     = 8'hC0;
	localparam logic [7:0] ADDR_LED       = 8'hC1;

	// slot indexes
	localparam int unsigned SLOT_W = 6;
	localparam logic [SLOT_W-1:0] SLOT_FRAME1_END = 6'd7;
	localparam logic [SLOT_W-1:0] SLOT_HDR_END    = 6'd7;
	localparam logic [SLOT_W-1:0] SLOT_LAST_WR    = 6'd23;
	localparam logic [SLOT_W-1:0] SLOT_LAST_RD    = 6'd39;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} lkp_state_t;

	// control from the sequencer to the key combiner
	typedef struct packed {
		logic load;
		logic shift;
	} lkp_acc_ctl_t;

	// 7-segment glyph table; blank beyond the table
	function automatic logic [6:0] glyph(input logic [5:0] sym);
		logic [7:0] g;
		begin
			case (sym)
				6'd0:  g = 8'h3F; 6'd1:  g = 8'h06; 6'd2:  g = 8'h5B; 6'd3:  g = 8'h4F;
				6'd4:  g = 8'h66; 6'd5:  g = 8'h6D; 6'd6:  g = 8'h7D; 6'd7:  g = 8'h07;
				6'd8:  g = 8'h7F; 6'd9:  g = 8'h6F; 6'd10: g = 8'h77; 6'd11: g = 8'h7C;
				6'd12: g = 8'h39; 6'd13: g = 8'h5E; 6'd14: g = 8'h79; 6'd15: g = 8'h71;
				6'd16: g = 8'h6F; 6'd17: g = 8'h3D; 6'd18: g = 8'h74; 6'd19: g = 8'h76;
				6'd20: g = 8'h05; 6'd21: g = 8'h06; 6'd22: g = 8'h0D; 6'd23: g = 8'h30;
				6'd24: g = 8'h38; 6'd25: g = 8'h54; 6'd26: g = 8'h37; 6'd27: g = 8'h5C;
				6'd28: g = 8'h3F; 6'd29: g = 8'h73; 6'd30: g = 8'h67; 6'd31: g = 8'h50;
				6'd32: g = 8'h6D; 6'd33: g = 8'h78; 6'd34: g = 8'h1C; 6'd35: g = 8'h3E;
				6'd36: g = 8'h66; 6'd37: g = 8'h08; 6'd38: g = 8'h40; 6'd39: g = 8'h01;
				default: g = 8'h00;
			endcase
			return g[6:0];
		end
	endfunction

endpackage

FILE: rtl/lkp_cmd_if.sv
// Command channel for the panel serial master.
// Valid/ready handshake with the command fields; no dependencies.
interface lkp_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [5:0]  symbol;
	logic        dot;
	logic [2:0]  position;
	logic [7:0]  led_value;
	logic [31:0] key_scan;

	modport source (output valid, cmd, symbol, dot, position, led_value, key_scan,
		input ready);
	modport sink (input valid, cmd, symbol, dot, position, led_value, key_scan,
		output ready);
endinterface

FILE: rtl/lkp_slot_if.sv
// Bit slot channel of the panel serial master.
// Valid/ready handshake carrying one bit slot per request; no dependencies.
interface lkp_slot_if;
	logic       valid;
	logic       ready;
	logic       strobe_active;
	logic       drive_data;
	logic       data_bit;
	logic       end_of_frame;
	logic [7:0] keys;
	logic       last;

	modport source (output valid, strobe_active, drive_data, data_bit, end_of_frame, keys,
		last, input ready);
	modport sink (input valid, strobe_active, drive_data, data_bit, end_of_frame, keys,
		last, output ready);
endinterface

FILE: rtl/lkp_key_acc.sv
// Bit-serial key combiner: folds the sampled key bytes into one key byte.
// Depends on lkp_pkg.
module lkp_key_acc
	import lkp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lkp_acc_ctl_t ctl,
	input  logic [31:0]  key_scan,
	output logic [7:0]   keys_nxt
);

	logic [31:0] scan_q;
	logic [4:0]  idx_q;
	logic [7:0]  keys_q;
	logic [3:0]  target;
	logic [7:0]  contrib;

	// bit j of byte i lands at key bit i + j when that is below 8
	assign target  = {2'b00, idx_q[4:3]} + {1'b0, idx_q[2:0]};
	assign contrib = (scan_q[0] && !target[3]) ? (8'd1 << target[2:0]) : 8'd0;
	assign keys_nxt = keys_q | contrib;

	// sampled bits consumed one per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			keys_q <= '0;
		end else if (ctl.load) begin
			idx_q  <= '0;
			keys_q <= '0;
		end else if (ctl.shift) begin
			idx_q  <= idx_q + 5'd1;
			keys_q <= keys_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			scan_q <= key_scan;
		end else if (ctl.shift) begin
			scan_q <= {1'b0, scan_q[31:1]};
		end
	end

endmodule

FILE: rtl/led_key_panel_serial_master.sv
// Three-wire LED-and-key panel serial master: one command in, one bit slot per request out,
// LSB first. A digit or LED write gives 24 slots, a key read 40 (8 driven, 32 sampled). The
// block emits one slot per clock while the result side takes them. A command is taken only
// while the block is idle and its slots follow. The slot count is set by the last-slot
// constants SLOT_LAST_WR and SLOT_LAST_RD, held in last_q. After a command is taken, its first
// slot enters the output register once that register is empty or being read. A new command
// is taken as soon as the last slot of the previous one sits in the output register; the
// unused command code is taken and gives no slots.
// Depends on lkp_pkg, lkp_cmd_if, lkp_slot_if and lkp_key_acc.
module led_key_panel_serial_master
	import lkp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lkp_cmd_if.sink    command,
	lkp_slot_if.source result
);

	lkp_state_t       state_q, state_n;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] last_q;
	logic             is_read_q;
	logic [23:0]      shift_q;
	logic [23:0]      load_data;
	logic             cmd_acc;
	logic             adv;
	logic             drive;
	logic             bit_v;
	logic             eof;
	logic             fin;
	logic [7:0]       keys_v;
	logic [7:0]       keys_nxt;
	lkp_acc_ctl_t     acc_ctl;

	logic             res_valid_q;
	logic             res_drive_q;
	logic             res_bit_q;
	logic             res_eof_q;
	logic [7:0]       res_keys_q;
	logic             res_last_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc && command.cmd != CMD_NONE) state_n = ST_RUN;
			end
			ST_RUN: begin
				if (adv && fin) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		command.ready = 1'b0;
		adv           = 1'b0;
		case (state_q)
			ST_IDLE: command.ready = 1'b1;
			ST_RUN:  adv = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	assign cmd_acc = command.valid && command.ready;

	// frame bytes, first byte lowest
	always_comb begin
		case (command.cmd)
			CMD_DIGIT: load_data = {command.dot, glyph(command.symbol),
				ADDR_DIGIT | {4'b0000, command.position, 1'b0}, OP_WRITE_FIXED};
			CMD_LED:   load_data = {command.led_value,
				ADDR_LED | {4'b0000, command.position, 1'b0}, OP_WRITE_LED};
			CMD_READ:  load_data = {16'h0000, OP_READ_KEYS};
			default:   load_data = '0;
		endcase
	end

	// current slot
	assign fin    = (slot_q == last_q);
	assign drive  = !(is_read_q && slot_q > SLOT_HDR_END);
	assign bit_v  = drive && shift_q[0];
	assign eof    = is_read_q ? fin : (fin || slot_q == SLOT_FRAME1_END);
	assign keys_v = (is_read_q && fin) ? keys_nxt : 8'h00;

	assign acc_ctl.load  = cmd_acc;
	assign acc_ctl.shift = adv && !drive;

	lkp_key_acc u_key_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (acc_ctl),
		.key_scan (command.key_scan),
		.keys_nxt (keys_nxt)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd_acc) begin
				slot_q <= '0;
			end else if (adv) begin
				slot_q <= slot_q + 6'd1;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// frame shift register and command kind
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			shift_q   <= load_data;
			is_read_q <= (command.cmd == CMD_READ);
			last_q    <= (command.cmd == CMD_READ) ? SLOT_LAST_RD : SLOT_LAST_WR;
		end else if (adv) begin
			shift_q <= {1'b0, shift_q[23:1]};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_drive_q <= drive;
			res_bit_q   <= bit_v;
			res_eof_q   <= eof;
			res_keys_q  <= keys_v;
			res_last_q  <= fin;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.strobe_active = 1'b1;
	assign result.drive_data    = res_drive_q;
	assign result.data_bit      = res_bit_q;
	assign result.end_of_frame  = res_eof_q;
	assign result.keys          = res_keys_q;
	assign result.last          = res_last_q;

	// the final slot of a command always closes a frame
	a_last_eof: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_last_q |-> res_eof_q)
		else $error("last slot without end of frame");

	// key byte only shows on the final slot
	a_keys_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_last_q |-> res_keys_q == 8'h00)
		else $error("key byte on a slot other than the last");

	// released data line carries zero
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_drive_q |-> !res_bit_q)
		else $error("data bit set while sampling");

	// slot counter stays within the command
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> slot_q <= last_q)
		else $error("slot counter overran the command");

endmodule

FILE: test/tb.sv
// Regression bench for led_key_panel_serial_master: random and directed panel requests,
// with every bit slot predicted in the bench and checked against the result channel.
// Depends on lkp_pkg, lkp_cmd_if, lkp_slot_if and the block itself.
module tb;
	import lkp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned RANDOM_REQS  = 190;
	localparam int unsigned QUIET_REQS   = 30;
	localparam int unsigned HOLD_AFTER   = 400;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned PRINT_LIMIT  = 40;

	// 7-segment patterns, bit 7 left clear for the decimal point
	localparam logic [7:0] SEGMENT_PATTERNS [40] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h3D, 8'h74, 8'h76,
		8'h05, 8'h06, 8'h0D, 8'h30, 8'h38, 8'h54, 8'h37, 8'h5C, 8'h3F, 8'h73,
		8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h66, 8'h08, 8'h40, 8'h01
	};

	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  symbol;
		logic        dot;
		logic [2:0]  position;
		logic [7:0]  led_value;
		logic [31:0] key_scan;
	} panel_req_t;

	typedef struct {
		logic       strobe_active;
		logic       drive_data;
		logic       data_bit;
		logic       end_of_frame;
		logic [7:0] keys;
		logic       last;
	} bit_slot_t;

	logic clk = 1'b0;
	logic arst_n;

	lkp_cmd_if  cmd_ch ();
	lkp_slot_if slot_ch ();

	led_key_panel_serial_master uut (
		.clk    (clk),
		.arst_n (arst_n),
		.command(cmd_ch),
		.result (slot_ch)
	);

	panel_req_t pending_reqs [$];
	bit_slot_t  expected_slots [$];
	panel_req_t offered_req;

	int unsigned cycle_count = 0;
	int unsigned total_reqs = 0;
	int unsigned reqs_accepted = 0;
	int unsigned slots_taken = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	bit          long_hold_done = 1'b0;
	bit          timed_out;
	logic        quiet_tail;

	// no idling once the run nears its end
	assign quiet_tail = (reqs_accepted + QUIET_REQS >= total_reqs);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH @%0t slot %0d: %s got %0h want %0h",
				$time, slots_taken, what, got, want);
		mismatches++;
	endtask

	// expected slot stream for one request

	function automatic void push_slot(input logic drive, input logic bit_val,
		input logic eof, input logic [7:0] keys, input logic fin);
		bit_slot_t s;
		s.strobe_active = 1'b1;
		s.drive_data    = drive;
		s.data_bit      = bit_val;
		s.end_of_frame  = eof;
		s.keys          = keys;
		s.last          = fin;
		expected_slots.push_back(s);
	endfunction

	// one byte LSB first; close ends the frame, fin ends the command
	function automatic void push_byte(input logic [7:0] data, input bit close, input bit fin);
		for (int i = 0; i < 8; i++)
			push_slot(1'b1, data[i], close && i == 7, 8'h00, fin && i == 7);
	endfunction

	function automatic void predict_slots(input panel_req_t r);
		logic [7:0] pattern;
		logic [7:0] keys;
		logic [7:0] scan_byte;
		case (r.cmd)
			CMD_DIGIT: begin
				pattern = (r.symbol < 40) ? SEGMENT_PATTERNS[r.symbol] : 8'h00;
				pattern = {r.dot, pattern[6:0]};
				push_byte(OP_WRITE_FIXED, 1'b1, 1'b0);
				push_byte(ADDR_DIGIT | {4'b0, r.position, 1'b0}, 1'b0, 1'b0);
				push_byte(pattern, 1'b1, 1'b1);
			end
			CMD_LED: begin
				push_byte(OP_WRITE_LED, 1'b1, 1'b0);
				push_byte(ADDR_LED + {4'b0, r.position, 1'b0}, 1'b0, 1'b0);
				push_byte(r.led_value, 1'b1, 1'b1);
			end
			CMD_READ: begin
				keys = 8'h00;
				for (int i = 0; i < 4; i++) begin
					scan_byte = r.key_scan[8*i +: 8];
					keys = keys | (scan_byte << i);
				end
				push_byte(OP_READ_KEYS, 1'b0, 1'b0);
				// data line released while the chip answers
				for (int i = 0; i < 32; i++)
					push_slot(1'b0, 1'b0, i == 31, (i == 31) ? keys : 8'h00, i == 31);
			end
			default: ;
		endcase
	endfunction

	function automatic panel_req_t make_req(input logic [1:0] cmd, input logic [5:0] symbol,
		input logic dot, input logic [2:0] position, input logic [7:0] led_value,
		input logic [31:0] key_scan);
		panel_req_t r;
		r.cmd       = cmd;
		r.symbol    = symbol;
		r.dot       = dot;
		r.position  = position;
		r.led_value = led_value;
		r.key_scan  = key_scan;
		return r;
	endfunction

	function automatic panel_req_t random_req(input logic [1:0] cmd);
		logic [5:0] symbol;
		// mostly symbols inside the glyph table
		symbol = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 39));
		return make_req(cmd, symbol, 1'($urandom), 3'($urandom), 8'($urandom), $urandom);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid     <= 1'b0;
			cmd_ch.cmd       <= CMD_DIGIT;
			cmd_ch.symbol    <= '0;
			cmd_ch.dot       <= 1'b0;
			cmd_ch.position  <= '0;
			cmd_ch.led_value <= '0;
			cmd_ch.key_scan  <= '0;
			send_gap = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_slots(offered_req);
				reqs_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					offered_req = pending_reqs.pop_front();
					cmd_ch.valid     <= 1'b1;
					cmd_ch.cmd       <= offered_req.cmd;
					cmd_ch.symbol    <= offered_req.symbol;
					cmd_ch.dot       <= offered_req.dot;
					cmd_ch.position  <= offered_req.position;
					cmd_ch.led_value <= offered_req.led_value;
					cmd_ch.key_scan  <= offered_req.key_scan;
					if (!quiet_tail && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 4);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_slot();
		bit_slot_t want;
		if (expected_slots.size() == 0) begin
			report_mismatch("unexpected slot, last", slot_ch.last, 0);
		end else begin
			want = expected_slots.pop_front();
			if (slot_ch.strobe_active !== want.strobe_active)
				report_mismatch("strobe_active", slot_ch.strobe_active, want.strobe_active);
			if (slot_ch.drive_data !== want.drive_data)
				report_mismatch("drive_data", slot_ch.drive_data, want.drive_data);
			if (slot_ch.data_bit !== want.data_bit)
				report_mismatch("data_bit", slot_ch.data_bit, want.data_bit);
			if (slot_ch.end_of_frame !== want.end_of_frame)
				report_mismatch("end_of_frame", slot_ch.end_of_frame, want.end_of_frame);
			if (slot_ch.keys !== want.keys)
				report_mismatch("keys", slot_ch.keys, want.keys);
			if (slot_ch.last !== want.last)
				report_mismatch("last", slot_ch.last, want.last);
		end
		slots_taken++;
	endtask

	// slot monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ch.ready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (slot_ch.valid && slot_ch.ready)
				check_slot();
			if (hold_left > 0) begin
				hold_left--;
				slot_ch.ready <= 1'b0;
			end else if (!long_hold_done && slots_taken >= HOLD_AFTER) begin
				// long stall so the block fills and holds off new requests
				long_hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				slot_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				slot_ch.ready <= 1'b0;
			end else begin
				slot_ch.ready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 7) == 0)
					recv_gap = $urandom_range(1, 4);
			end
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned n;
		logic [1:0] cmd;

		arst_n = 1'b0;

		// directed: field extremes, blank glyphs, unused code, ignored fields
		pending_reqs.push_back(make_req(CMD_DIGIT, 6'd0, 1'b0, 3'd0, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_DIGIT, 6'd39, 1'b1, 3'd7, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_DIGIT, 6'd8, 1'b1, 3'd5, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_DIGIT, 6'd40, 1'b0, 3'd3, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_DIGIT, 6'd63, 1'b1, 3'd2, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_DIGIT, 6'd21, 1'b0, 3'd6, 8'hFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(CMD_LED, 6'd0, 1'b0, 3'd0, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_LED, 6'd63, 1'b1, 3'd7, 8'hFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(CMD_LED, 6'd0, 1'b0, 3'd4, 8'hA5, 32'h0));
		pending_reqs.push_back(make_req(CMD_NONE, 6'd17, 1'b1, 3'd1, 8'h5A, 32'h1234_5678));
		pending_reqs.push_back(make_req(CMD_NONE, 6'd63, 1'b1, 3'd7, 8'hFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(CMD_READ, 6'd0, 1'b0, 3'd0, 8'h00, 32'h0000_0000));
		pending_reqs.push_back(make_req(CMD_READ, 6'd63, 1'b1, 3'd7, 8'hFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(CMD_READ, 6'd0, 1'b0, 3'd0, 8'h00, 32'h8040_2010));
		pending_reqs.push_back(make_req(CMD_READ, 6'd0, 1'b0, 3'd0, 8'h00, 32'h1234_5678));
		pending_reqs.push_back(make_req(CMD_NONE, 6'd0, 1'b0, 3'd0, 8'h00, 32'h0));
		pending_reqs.push_back(make_req(CMD_READ, 6'd0, 1'b0, 3'd0, 8'h00, 32'h0F0F_F0F0));

		// random: mostly real commands, a sprinkling of the unused code
		n = 0;
		while (n < RANDOM_REQS) begin
			cmd = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
			pending_reqs.push_back(random_req(cmd));
			if (cmd != CMD_NONE)
				n++;
		end
		total_reqs = pending_reqs.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cycle_count < CYCLE_LIMIT && (pending_reqs.size() != 0 || cmd_ch.valid
			|| expected_slots.size() != 0))
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		timed_out = (cycle_count >= CYCLE_LIMIT);
		if (!timed_out && expected_slots.size() != 0)
			report_mismatch("slots never delivered", 0, expected_slots.size());

		if (!timed_out && mismatches == 0)
			$display("led_key_panel_serial_master regression: pass");
		else
			$display("led_key_panel_serial_master regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lkp_pkg.sv
rtl/lkp_cmd_if.sv
rtl/lkp_slot_if.sv
rtl/lkp_key_acc.sv
rtl/led_key_panel_serial_master.sv
test/tb.sv
